[src/dlsr_pkg.sv]
`default_nettype none

package dlsr_pkg;

  localparam int unsigned SLOW_PASS_COUNT = 2;
  localparam int unsigned CODE_READ_LIMIT = 4;

  localparam int unsigned WAKE_LEN = 18;
  localparam int unsigned CNT_W    = 5;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [16:0] ELAPSED_MAX   = 17'h1ffff;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [10:0] GAP_NONE   = 11'd0;
  localparam logic [10:0] GAP_WAKE   = 11'd420;
  localparam logic [10:0] GAP_FAST_1 = 11'd426;
  localparam logic [10:0] GAP_FAST_2 = 11'd15;
  localparam logic [10:0] GAP_SLOW_1 = 11'd1420;
  localparam logic [10:0] GAP_SLOW_2 = 11'd60;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_START = 2'd2,
    MODE_SLOW  = 2'd3
  } mode_e;

  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_WAIT_FAST   = 7'b0000010,
    PH_ANSWER_FAST = 7'b0000100,
    PH_SLOW        = 7'b0001000,
    PH_REQUEST     = 7'b0010000,
    PH_SHORT       = 7'b0100000,
    PH_READ        = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    JOB_WAKE  = 2'd0,
    JOB_REPLY = 2'd1,
    JOB_CODE  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        gap_slow;
    logic [11:0] code;
    logic        baud_fast;
    logic [2:0]  phase_now;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_pop_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] c;
    unique case (ph)
      PH_IDLE:        c = 3'd0;
      PH_WAIT_FAST:   c = 3'd1;
      PH_ANSWER_FAST: c = 3'd2;
      PH_SLOW:        c = 3'd3;
      PH_REQUEST:     c = 3'd4;
      PH_SHORT:       c = 3'd5;
      PH_READ:        c = 3'd6;
      default:        c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sync_word(logic [1:0] k);
    logic [7:0] w;
    unique case (k)
      2'd0:    w = 8'ha0;
      2'd1:    w = 8'hb1;
      2'd2:    w = 8'h82;
      default: w = 8'h93;
    endcase
    return w;
  endfunction

  // first byte in the upper half
  function automatic logic [15:0] reply_fast(logic [1:0] k);
    logic [15:0] p;
    unique case (k)
      2'd0:    p = 16'h01b0;
      2'd1:    p = 16'hff5f;
      2'd2:    p = 16'h8174;
      default: p = 16'h00a0;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] reply_slow(logic [1:0] k);
    logic [15:0] p;
    unique case (k)
      2'd0:    p = 16'h01b0;
      2'd1:    p = 16'hff5f;
      2'd2:    p = 16'h01f4;
      default: p = 16'h00a0;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] reply_req(logic [1:0] k);
    logic [15:0] p;
    unique case (k)
      2'd0:    p = 16'h01b0;
      2'd1:    p = 16'hff5f;
      2'd2:    p = 16'h26a4;
      default: p = 16'h00a0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] wake_byte(logic [CNT_W-1:0] i);
    logic [7:0] b;
    unique case (i)
      5'd12:   b = 8'h01;
      5'd13:   b = 8'h04;
      5'd17:   b = 8'h05;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[src/dlsr_if.sv]
`default_nettype none

interface dlsr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface dlsr_rsp_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [10:0] gap_us;
  logic        code_valid;
  logic [11:0] error_code;
  logic        baud_fast;
  logic [2:0]  phase_now;
  logic        last;

  modport source (
    output valid, output tx_valid, output tx_byte, output gap_us,
    output code_valid, output error_code, output baud_fast,
    output phase_now, output last, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input gap_us,
    input code_valid, input error_code, input baud_fast,
    input phase_now, input last, output ready
  );
endinterface

`default_nettype wire

[src/diagnostic_link_sync_responder_top.sv]
// diagnostic link sync responder
// req_i carries one request per handshake: mode (received byte, ms tick,
// start command, go to slow sync) and rx_byte. rsp_o carries the results of
// each request in order, the final one flagged by last; a request that sends
// nothing and reads no code produces no result.
// the front stage takes one request per cycle while the queue is not full and
// updates the sync state in that cycle; its work goes into a two-entry job
// queue, the back stage expands each job into results at one per cycle while
// rsp_o is ready. a job passes through the queue memory and the back stage's
// job register before its first result is valid. a start or timeout yields
// 18 results, a reply 2, a code read 1, so the output side sets the sustained
// rate; requests keep flowing while the queue has room and req_i.ready drops
// when it is full. a stall on rsp_o holds the current result; the queue then
// fills and the front stalls too, without losing anything. cfg_we_i writes
// the timeout limit in ms (reset 1000); the user must write it only while the
// block is idle, which the block itself does not enforce. reset: phase idle,
// slow baud, window and counters cleared, queue empty.
`default_nettype none

module diagnostic_link_sync_responder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  dlsr_req_if.sink         req_i,
  dlsr_rsp_if.source       rsp_o
);

  dlsr_pkg::q_push_t push;
  dlsr_pkg::q_pop_t  pop;
  logic              full;
  logic              pop_ready;

  dlsr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push)
  );

  dlsr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pop_o       (pop),
    .pop_ready_i (pop_ready)
  );

  dlsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

[src/dlsr_front.sv]
`default_nettype none

module dlsr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [15:0]    cfg_wdata_i,
  dlsr_req_if.sink            req_i,
  input  wire logic           full_i,
  output dlsr_pkg::q_push_t   push_o
);

  dlsr_pkg::phase_e  phase_q, phase_d;
  logic [3:0][7:0]   win_q, win_d, win_s;
  logic [1:0]        idx_q, idx_d;
  logic [1:0]        passes_q, passes_d, passes_inc;
  logic              cbc_q, cbc_d;
  logic [2:0]        codes_q, codes_d, codes_inc;
  logic [16:0]       elapsed_q, elapsed_d, elapsed_inc;
  logic              rate_q, rate_d;
  logic [15:0]       limit_q;
  logic              accept, match, pass_done, has_job;
  logic [15:0]       pair;
  dlsr_pkg::job_t    job;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && req_i.ready;

  assign win_s       = {req_i.rx_byte, win_q[3], win_q[2], win_q[1]};
  assign match       = (win_s[0] == 8'd0) && (win_s[1] == 8'd0) && (win_s[2] == 8'd0) &&
                       (win_s[3] == dlsr_pkg::sync_word(idx_q));
  assign pass_done   = (idx_q == 2'd3);
  assign elapsed_inc = (elapsed_q == dlsr_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 17'd1;
  assign passes_inc  = passes_q + 2'd1;
  assign codes_inc   = (codes_q == 3'd7) ? codes_q : codes_q + 3'd1;

  always_comb begin
    phase_d  = phase_q;
    win_d    = win_q;
    idx_d    = idx_q;
    passes_d = passes_q;
    cbc_d    = cbc_q;
    codes_d  = codes_q;
    elapsed_d = elapsed_q;
    rate_d   = rate_q;
    has_job  = 1'b0;
    pair     = 16'd0;
    job      = '0;
    job.kind = dlsr_pkg::JOB_WAKE;

    unique case (dlsr_pkg::mode_e'(req_i.mode))
      dlsr_pkg::MODE_BYTE: begin
        unique case (phase_q)
          dlsr_pkg::PH_WAIT_FAST: begin
            win_d = win_s;
            if (match) begin
              win_d = '0;
              idx_d = idx_q + 2'd1;
              if (pass_done) begin
                phase_d = dlsr_pkg::PH_ANSWER_FAST;
              end
            end
          end
          dlsr_pkg::PH_ANSWER_FAST: begin
            win_d = win_s;
            if (match) begin
              has_job      = 1'b1;
              job.kind     = dlsr_pkg::JOB_REPLY;
              pair         = dlsr_pkg::reply_fast(idx_q);
              job.gap_slow = 1'b0;
              win_d        = '0;
              idx_d        = idx_q + 2'd1;
              if (pass_done) begin
                phase_d   = dlsr_pkg::PH_SLOW;
                rate_d    = 1'b0;
                elapsed_d = '0;
              end
            end
          end
          dlsr_pkg::PH_SLOW: begin
            win_d = win_s;
            if (match) begin
              has_job      = 1'b1;
              job.kind     = dlsr_pkg::JOB_REPLY;
              pair         = dlsr_pkg::reply_slow(idx_q);
              job.gap_slow = 1'b1;
              idx_d        = idx_q + 2'd1;
              if (pass_done) begin
                passes_d = passes_inc;
                if (passes_inc >= 2'(dlsr_pkg::SLOW_PASS_COUNT)) begin
                  passes_d = '0;
                  phase_d  = dlsr_pkg::PH_REQUEST;
                end
              end
            end
          end
          dlsr_pkg::PH_REQUEST: begin
            win_d = win_s;
            if (match) begin
              has_job      = 1'b1;
              job.kind     = dlsr_pkg::JOB_REPLY;
              pair         = dlsr_pkg::reply_req(idx_q);
              job.gap_slow = 1'b1;
              idx_d        = idx_q + 2'd1;
              if (pass_done) begin
                phase_d = dlsr_pkg::PH_SHORT;
              end
            end
          end
          dlsr_pkg::PH_SHORT: begin
            win_d = win_s;
            if (match) begin
              has_job      = 1'b1;
              job.kind     = dlsr_pkg::JOB_REPLY;
              pair         = dlsr_pkg::reply_req(2'd0);
              job.gap_slow = 1'b1;
              idx_d        = idx_q + 2'd1;
              phase_d      = dlsr_pkg::PH_READ;
            end
          end
          dlsr_pkg::PH_READ: begin
            win_d = win_s;
            cbc_d = !cbc_q;
            if (cbc_q) begin
              cbc_d    = 1'b0;
              has_job  = 1'b1;
              job.kind = dlsr_pkg::JOB_CODE;
              job.code = {win_s[3][3:0], win_s[2]};
              codes_d  = codes_inc;
              phase_d  = (codes_inc > 3'(dlsr_pkg::CODE_READ_LIMIT)) ?
                         dlsr_pkg::PH_IDLE : dlsr_pkg::PH_REQUEST;
            end
          end
          default: begin
          end
        endcase
      end
      dlsr_pkg::MODE_TICK: begin
        elapsed_d = elapsed_inc;
        if (((phase_q == dlsr_pkg::PH_WAIT_FAST) || (phase_q == dlsr_pkg::PH_SLOW)) &&
            (elapsed_inc > {1'b0, limit_q})) begin
          has_job   = 1'b1;
          job.kind  = dlsr_pkg::JOB_WAKE;
          phase_d   = dlsr_pkg::PH_WAIT_FAST;
          rate_d    = 1'b1;
          elapsed_d = '0;
        end
      end
      dlsr_pkg::MODE_START: begin
        has_job   = 1'b1;
        job.kind  = dlsr_pkg::JOB_WAKE;
        phase_d   = dlsr_pkg::PH_WAIT_FAST;
        rate_d    = 1'b1;
        elapsed_d = '0;
      end
      dlsr_pkg::MODE_SLOW: begin
        phase_d   = dlsr_pkg::PH_SLOW;
        rate_d    = 1'b0;
        elapsed_d = '0;
      end
      default: begin
      end
    endcase

    job.byte0     = pair[15:8];
    job.byte1     = pair[7:0];
    job.baud_fast = rate_d;
    job.phase_now = dlsr_pkg::phase_code(phase_d);
  end

  assign push_o.valid = accept && has_job;
  assign push_o.job   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dlsr_pkg::PH_IDLE;
      win_q     <= '0;
      idx_q     <= '0;
      passes_q  <= '0;
      cbc_q     <= 1'b0;
      codes_q   <= '0;
      elapsed_q <= '0;
      rate_q    <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      win_q     <= win_d;
      idx_q     <= idx_d;
      passes_q  <= passes_d;
      cbc_q     <= cbc_d;
      codes_q   <= codes_d;
      elapsed_q <= elapsed_d;
      rate_q    <= rate_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dlsr_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/dlsr_fifo.sv]
`default_nettype none

module dlsr_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dlsr_pkg::q_push_t push_i,
  output      logic           full_o,
  output      dlsr_pkg::q_pop_t pop_o,
  input  wire logic           pop_ready_i
);

  dlsr_pkg::job_t                  mem_q [dlsr_pkg::QDEPTH];
  logic [dlsr_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [dlsr_pkg::QCNT_W-1:0]     count_q;
  logic                            do_push, do_pop;

  assign full_o      = (count_q == dlsr_pkg::QCNT_W'(dlsr_pkg::QDEPTH));
  assign pop_o.valid = (count_q != '0);
  assign pop_o.job   = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_o.valid && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/dlsr_back.sv]
`default_nettype none

module dlsr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dlsr_pkg::q_pop_t pop_i,
  output      logic             pop_ready_o,
  dlsr_rsp_if.source            rsp_o
);

  dlsr_pkg::job_t               job_q;
  logic                         busy_q;
  logic [dlsr_pkg::CNT_W-1:0]   cnt_q;
  logic                         last_beat, first_beat, load;

  assign first_beat = (cnt_q == '0);

  always_comb begin
    rsp_o.tx_valid   = 1'b0;
    rsp_o.tx_byte    = 8'd0;
    rsp_o.gap_us     = dlsr_pkg::GAP_NONE;
    rsp_o.code_valid = 1'b0;
    rsp_o.error_code = 12'd0;
    last_beat        = 1'b1;
    unique case (job_q.kind)
      dlsr_pkg::JOB_WAKE: begin
        rsp_o.tx_valid = 1'b1;
        rsp_o.tx_byte  = dlsr_pkg::wake_byte(cnt_q);
        rsp_o.gap_us   = first_beat ? dlsr_pkg::GAP_NONE : dlsr_pkg::GAP_WAKE;
        last_beat      = (cnt_q == dlsr_pkg::CNT_W'(dlsr_pkg::WAKE_LEN - 1));
      end
      dlsr_pkg::JOB_REPLY: begin
        rsp_o.tx_valid = 1'b1;
        rsp_o.tx_byte  = first_beat ? job_q.byte0 : job_q.byte1;
        if (job_q.gap_slow) begin
          rsp_o.gap_us = first_beat ? dlsr_pkg::GAP_SLOW_1 : dlsr_pkg::GAP_SLOW_2;
        end else begin
          rsp_o.gap_us = first_beat ? dlsr_pkg::GAP_FAST_1 : dlsr_pkg::GAP_FAST_2;
        end
        last_beat = !first_beat;
      end
      dlsr_pkg::JOB_CODE: begin
        rsp_o.code_valid = 1'b1;
        rsp_o.error_code = job_q.code;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.valid     = busy_q;
  assign rsp_o.baud_fast = job_q.baud_fast;
  assign rsp_o.phase_now = job_q.phase_now;
  assign rsp_o.last      = last_beat;

  assign pop_ready_o = !busy_q || (rsp_o.ready && last_beat);
  assign load        = pop_ready_o && pop_i.valid;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= pop_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && rsp_o.ready) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/dlsr_chk.sv]
`default_nettype none

module dlsr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic        tx_valid_i,
  input wire logic [7:0]  tx_byte_i,
  input wire logic [10:0] gap_us_i,
  input wire logic        code_valid_i,
  input wire logic [11:0] error_code_i,
  input wire logic        last_i
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(tx_byte_i) && $stable(gap_us_i) &&
      $stable(error_code_i) && $stable(last_i))
    else $error("result changed under stall");

  // code read is a single result with no byte
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && code_valid_i |-> !tx_valid_i && last_i && tx_byte_i == 8'd0 &&
      gap_us_i == 11'd0)
    else $error("code result malformed");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && tx_valid_i |-> gap_us_i == 11'd0 || gap_us_i == 11'd15 ||
      gap_us_i == 11'd60 || gap_us_i == 11'd420 || gap_us_i == 11'd426 ||
      gap_us_i == 11'd1420)
    else $error("unexpected gap");

  // a zero gap only opens a wake message, whose byte is zero
  a_wake_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && tx_valid_i && gap_us_i == 11'd0 |-> tx_byte_i == 8'd0 && !last_i)
    else $error("bad wake start");

endmodule

bind diagnostic_link_sync_responder_top dlsr_chk u_dlsr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (rsp_o.valid),
  .ready_i      (rsp_o.ready),
  .tx_valid_i   (rsp_o.tx_valid),
  .tx_byte_i    (rsp_o.tx_byte),
  .gap_us_i     (rsp_o.gap_us),
  .code_valid_i (rsp_o.code_valid),
  .error_code_i (rsp_o.error_code),
  .last_i       (rsp_o.last)
);

`default_nettype wire

[tb/diagnostic_link_sync_responder_top_tb.sv]
`default_nettype none

module diagnostic_link_sync_responder_top_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    PC_IDLE,
    PC_WAIT_FAST,
    PC_ANSWER_FAST,
    PC_SLOW,
    PC_REQUEST,
    PC_SHORT,
    PC_READ
  } phase_code_e;

  localparam logic [3:0][7:0] SYNC_WORDS = {8'h93, 8'h82, 8'hb1, 8'ha0};
  // first byte in the upper half
  localparam logic [3:0][15:0] FAST_REPLIES = {16'h00a0, 16'h8174, 16'hff5f, 16'h01b0};
  localparam logic [3:0][15:0] SLOW_REPLIES = {16'h00a0, 16'h01f4, 16'hff5f, 16'h01b0};
  localparam logic [3:0][15:0] REQ_REPLIES  = {16'h00a0, 16'h26a4, 16'hff5f, 16'h01b0};
  localparam logic [17:0][7:0] WAKE_BYTES =
    {8'h05, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 96'h0};

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [10:0] gap_us;
    logic        code_valid;
    logic [11:0] error_code;
    logic        baud_fast;
    logic [2:0]  phase_now;
    logic        last;
  } link_result_t;

  class link_sync_scoreboard;
    logic [15:0]  timeout_ms;
    phase_code_e  phase;
    logic [7:0]   win [4];
    logic [2:0]   sync_idx;
    logic [1:0]   slow_passes;
    logic         code_half;
    logic [2:0]   codes_read;
    logic [16:0]  elapsed;
    logic         fast;
    link_result_t batch[$];
    link_result_t due[$];
    int           errors;
    int           requests;
    int           results;
    int           codes_seen;
    int           wakes;
    int           limit_writes;

    function new();
      timeout_ms = dlsr_pkg::TIMEOUT_RESET;
      phase = PC_IDLE;
      foreach (win[i]) win[i] = 8'h00;
      sync_idx = 3'd0;
      slow_passes = 2'd0;
      code_half = 1'b0;
      codes_read = 3'd0;
      elapsed = 17'd0;
      fast = 1'b0;
      errors = 0;
      requests = 0;
      results = 0;
      codes_seen = 0;
      wakes = 0;
      limit_writes = 0;
    endfunction

    function void emit(logic txv, logic [7:0] txb, logic [10:0] gap, logic cv,
                       logic [11:0] code);
      link_result_t r;
      r = '0;
      r.tx_valid = txv;
      r.tx_byte = txb;
      r.gap_us = gap;
      r.code_valid = cv;
      r.error_code = code;
      batch.push_back(r);
    endfunction

    function void send_pair(logic [15:0] pair, logic [10:0] g1, logic [10:0] g2);
      emit(1'b1, pair[15:8], g1, 1'b0, 12'd0);
      emit(1'b1, pair[7:0], g2, 1'b0, 12'd0);
    endfunction

    function void send_wake();
      int i;
      for (i = 0; i < dlsr_pkg::WAKE_LEN; i++)
        emit(1'b1, WAKE_BYTES[i], (i == 0) ? dlsr_pkg::GAP_NONE : dlsr_pkg::GAP_WAKE,
             1'b0, 12'd0);
      phase = PC_WAIT_FAST;
      fast = 1'b1;
      elapsed = 17'd0;
      wakes++;
    endfunction

    function void enter_slow();
      phase = PC_SLOW;
      fast = 1'b0;
      elapsed = 17'd0;
    endfunction

    function void clear_window();
      foreach (win[i]) win[i] = 8'h00;
    endfunction

    function bit advance_pass();
      sync_idx = sync_idx + 3'd1;
      if (sync_idx > 3'd3) begin
        sync_idx = 3'd0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [1:0] k;
      bit hit;
      if (phase == PC_IDLE || phase > PC_READ) return;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = win[3];
      win[3] = b;
      k = sync_idx[1:0];
      hit = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h00) &&
            (win[3] == SYNC_WORDS[k]);
      case (phase)
        PC_WAIT_FAST: if (hit) begin
          clear_window();
          if (advance_pass()) phase = PC_ANSWER_FAST;
        end
        PC_ANSWER_FAST: if (hit) begin
          send_pair(FAST_REPLIES[k], dlsr_pkg::GAP_FAST_1, dlsr_pkg::GAP_FAST_2);
          clear_window();
          if (advance_pass()) enter_slow();
        end
        PC_SLOW: if (hit) begin
          send_pair(SLOW_REPLIES[k], dlsr_pkg::GAP_SLOW_1, dlsr_pkg::GAP_SLOW_2);
          if (advance_pass()) begin
            slow_passes = slow_passes + 2'd1;
            if (slow_passes >= dlsr_pkg::SLOW_PASS_COUNT) begin
              slow_passes = 2'd0;
              phase = PC_REQUEST;
            end
          end
        end
        PC_REQUEST: if (hit) begin
          send_pair(REQ_REPLIES[k], dlsr_pkg::GAP_SLOW_1, dlsr_pkg::GAP_SLOW_2);
          if (advance_pass()) phase = PC_SHORT;
        end
        PC_SHORT: if (hit) begin
          send_pair(REQ_REPLIES[0], dlsr_pkg::GAP_SLOW_1, dlsr_pkg::GAP_SLOW_2);
          sync_idx = {1'b0, sync_idx[1:0] + 2'd1};
          phase = PC_READ;
        end
        default: begin
          if (code_half) begin
            code_half = 1'b0;
            emit(1'b0, 8'h00, dlsr_pkg::GAP_NONE, 1'b1, {win[3][3:0], win[2]});
            if (codes_read < 3'd7) codes_read = codes_read + 3'd1;
            phase = (codes_read > dlsr_pkg::CODE_READ_LIMIT) ? PC_IDLE : PC_REQUEST;
          end else begin
            code_half = 1'b1;
          end
        end
      endcase
    endfunction

    function void note_request(dlsr_pkg::mode_e m, logic [7:0] b);
      link_result_t r;
      batch.delete();
      requests++;
      case (m)
        dlsr_pkg::MODE_BYTE: take_byte(b);
        dlsr_pkg::MODE_TICK: begin
          if (elapsed < dlsr_pkg::ELAPSED_MAX) elapsed = elapsed + 17'd1;
          if ((phase == PC_WAIT_FAST || phase == PC_SLOW) && elapsed > {1'b0, timeout_ms})
            send_wake();
        end
        dlsr_pkg::MODE_START: send_wake();
        default: enter_slow();
      endcase
      foreach (batch[i]) begin
        r = batch[i];
        r.baud_fast = fast;
        r.phase_now = phase;
        r.last = (i == batch.size() - 1);
        due.push_back(r);
      end
    endfunction

    function string show(link_result_t r);
      return $sformatf("tx %0d/%02h gap %0d code %0d/%03h baud %0d phase %0d last %0d",
                       r.tx_valid, r.tx_byte, r.gap_us, r.code_valid, r.error_code,
                       r.baud_fast, r.phase_now, r.last);
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      results++;
      if (got.code_valid) codes_seen++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: got %s", show(got));
        return;
      end
      want = due.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: want %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;

  link_sync_scoreboard link_sb;

  dlsr_req_if req_ch ();
  dlsr_rsp_if rsp_ch ();

  diagnostic_link_sync_responder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    link_result_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.tx_valid = rsp_ch.tx_valid;
        got.tx_byte = rsp_ch.tx_byte;
        got.gap_us = rsp_ch.gap_us;
        got.code_valid = rsp_ch.code_valid;
        got.error_code = rsp_ch.error_code;
        got.baud_fast = rsp_ch.baud_fast;
        got.phase_now = rsp_ch.phase_now;
        got.last = rsp_ch.last;
        link_sb.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_req(dlsr_pkg::mode_e m, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.rx_byte <= b;
    do @(posedge clk_i); while (!req_ch.ready);
    link_sb.note_request(m, b);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (link_sb.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    link_sb.timeout_ms = v;
    link_sb.limit_writes++;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_req(dlsr_pkg::MODE_BYTE, bytes[i]);
  endtask

  task automatic run_directed();
    send_req(dlsr_pkg::MODE_BYTE, 8'hff);
    send_req(dlsr_pkg::MODE_TICK, 8'h00);
    send_req(dlsr_pkg::MODE_SLOW, 8'h5a);
    send_req(dlsr_pkg::MODE_START, 8'ha5);
    send_req(dlsr_pkg::MODE_TICK, 8'h00);
    // one byte suffices after a cleared window
    send_bytes('{8'h00, 8'h00, 8'h00, 8'ha0, 8'hb1, 8'h82, 8'h93});
    send_bytes('{8'ha0, 8'h00, 8'hb1});
    send_req(dlsr_pkg::MODE_SLOW, 8'h00);
    send_bytes('{8'h00, 8'h00, 8'h00, 8'ha0});
    send_req(dlsr_pkg::MODE_START, 8'hff);

    wait_drained();
    write_limit(16'd0);
    send_req(dlsr_pkg::MODE_TICK, 8'h33);
    wait_drained();
    write_limit(16'd2);
    repeat (3) send_req(dlsr_pkg::MODE_TICK, 8'hcc);
    wait_drained();
    write_limit(dlsr_pkg::TIMEOUT_RESET);
    repeat (5) send_req(dlsr_pkg::MODE_TICK, 8'h0f);
    wait_drained();
    // limit dropped below the elapsed count
    write_limit(16'd3);
    send_req(dlsr_pkg::MODE_TICK, 8'hf0);
    wait_drained();
    write_limit(16'hffff);
    repeat (4) send_req(dlsr_pkg::MODE_TICK, 8'($urandom_range(255)));
  endtask

  task automatic drive_sessions(int count);
    logic [7:0] plan[$];
    int n;
    int r;
    dlsr_pkg::mode_e m;
    logic [7:0] b;
    bit ignored;
    n = 0;
    while (n < count) begin
      r = $urandom_range(999);
      b = 8'($urandom_range(255));
      m = dlsr_pkg::MODE_BYTE;
      if (r < 20) begin
        m = dlsr_pkg::MODE_TICK;
      end else if (r < 28) begin
        m = dlsr_pkg::MODE_SLOW;
      end else if (r < 33) begin
        m = dlsr_pkg::MODE_START;
      end else if (r < 90) begin
        m = dlsr_pkg::MODE_BYTE;
      end else if (link_sb.phase == PC_IDLE) begin
        m = dlsr_pkg::MODE_START;
        plan.delete();
      end else begin
        if (plan.size() == 0) begin
          if (link_sb.phase == PC_READ)
            plan = '{b, 8'($urandom_range(255))};
          else
            plan = '{8'h00, 8'h00, 8'h00, SYNC_WORDS[link_sb.sync_idx[1:0]]};
        end
        b = plan.pop_front();
      end
      ignored = (m == dlsr_pkg::MODE_BYTE) && (link_sb.phase == PC_IDLE);
      send_req(m, b);
      if (!ignored) n++;
    end
  endtask

  task automatic run_phase(int idle, int stall, logic [15:0] limit, int count);
    wait_drained();
    write_limit(limit);
    send_idle_pct = idle;
    stall_pct = stall;
    drive_sessions(count);
  endtask

  initial begin
    link_sb = new();
    req_ch.valid <= 1'b0;
    req_ch.mode <= dlsr_pkg::MODE_BYTE;
    req_ch.rx_byte <= 8'h00;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'h0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(0, 0, 16'($urandom_range(4, 40)), 72);
    run_phase(77, 0, 16'd0, 72);
    run_phase(0, 77, 16'($urandom_range(1, 65534)), 72);
    run_phase(6, 6, 16'hffff, 72);
    wait_drained();

    $display("covered %0d requests, %0d results, %0d wake messages, %0d error codes",
             link_sb.requests, link_sb.results, link_sb.wakes, link_sb.codes_seen);
    $display("timeout limit set %0d times, code reads reached %0d, %0d mismatches",
             link_sb.limit_writes, link_sb.codes_read, link_sb.errors);
    if (link_sb.errors == 0 && link_sb.due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
